@@ sv/cidf_pkg.sv @@
package cidf_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned CmpW = 9;
  localparam int unsigned KeyW = 12;
  localparam int unsigned CfgW = 6;

  localparam logic [KeyW-1:0] RtrBit   = 12'h800;
  localparam logic [KeyW-1:0] FullMask = 12'hFFF;
  localparam logic [CfgW-1:0] CfgReset = 6'd32;

  localparam logic KindWrite = 1'b0;
  localparam logic KindFrame = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusIllegal = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  entry_index;
    logic [10:0] frame_ident;
    logic        remote_flag;
    logic [10:0] accept_mask;
  } filt_req_t;

  typedef struct packed {
    logic       status;
    logic       matched;
    logic       dispatch;
    logic [4:0] match_index;
  } filt_rsp_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [KeyW-1:0] ident;
    logic [KeyW-1:0] mask;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } filt_state_e;

endpackage

@@ sv/cidf_table.sv @@
module cidf_table import cidf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_wr_t         wr_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic [KeyW-1:0] key_i,
  output logic            hit_o,
  output logic            handler_o
);

  logic [KeyW-1:0]         ident_mem [TableEntries];
  logic [KeyW-1:0]         mask_mem  [TableEntries];
  logic [TableEntries-1:0] written_q;
  logic [KeyW-1:0]         rd_ident_q;
  logic [KeyW-1:0]         rd_mask_q;
  logic                    rd_written_q;
  logic [KeyW-1:0]         eff_ident;
  logic [KeyW-1:0]         eff_mask;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ident_mem[wr_i.addr] <= wr_i.ident;
      mask_mem[wr_i.addr]  <= wr_i.mask;
    end
    if (rd_en_i) begin
      rd_ident_q <= ident_mem[rd_addr_i];
      rd_mask_q  <= mask_mem[rd_addr_i];
    end
  end

  // A written entry also owns a handler; unwritten entries read as reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign eff_ident = rd_written_q ? rd_ident_q : '0;
  assign eff_mask  = rd_written_q ? rd_mask_q : FullMask;
  assign hit_o     = ((key_i ^ eff_ident) & eff_mask) == '0;
  assign handler_o = rd_written_q;

endmodule

@@ sv/can_id_mask_acceptance_filter_top.sv @@
// CAN identifier/mask acceptance filter. Each request either writes one filter
// entry (kind 0: identifier, RTR flag and mask; RTR is always compared) or
// matches a received frame (kind 1) against entries 0 .. count-1, where count
// is the configured entries_in_use saturated to the table size. The first
// entry with ((key ^ ident) & mask) == 0 wins; the response reports the hit,
// its index and whether the entry has a handler. A write at or beyond count
// is refused with status 1. Entries never written hold identifier 0 and a
// full mask with no handler, so they catch data frames with identifier 0.
// Timing: one request at a time. A write goes straight to the response; a
// frame issues one table read per cycle through a single read port, compares
// each entry in the cycle after its read and stops at the first hit or after
// entry count-1, and goes straight to the response when count is zero. A
// response is held until taken, then the block returns to idle. The
// configuration channel is always ready; write it only while no request is in flight.
module can_id_mask_acceptance_filter_top import cidf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  filt_req_t       req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output filt_rsp_t       rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i
);

  filt_state_e     state_q, state_d;
  logic [CfgW-1:0] cfg_q;
  logic [KeyW-1:0] key_q, key_d;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic            issued_q, issued_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  filt_rsp_t       rsp_q, rsp_d;

  logic [CntW-1:0] count;
  logic [IdxW-1:0] last_idx;
  logic            req_fire;
  logic            in_range;
  tbl_wr_t         tbl_wr;
  logic            rd_en;
  logic            hit;
  logic            handler;

  // Saturate the configured count to the table size.
  assign count = ({{(CmpW-CfgW){1'b0}}, cfg_q} > CmpW'(TableEntries)) ?
                 CntW'(TableEntries) : CntW'(cfg_q);
  assign last_idx = IdxW'(count - CntW'(1));

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_OUT);
  assign rsp_o       = rsp_q;
  assign cfg_ready_o = 1'b1;
  assign req_fire    = req_valid_i && req_ready_o;
  assign in_range    = CmpW'(req_i.entry_index) < CmpW'(count);

  // Table write: store the key and force RTR into the mask.
  always_comb begin
    tbl_wr.en    = req_fire && (req_i.kind == KindWrite) && in_range;
    tbl_wr.addr  = IdxW'(req_i.entry_index);
    tbl_wr.ident = {req_i.remote_flag, req_i.frame_ident};
    tbl_wr.mask  = {1'b0, req_i.accept_mask} | RtrBit;
  end

  assign rd_en = (state_q == S_SCAN) && !issued_q;

  cidf_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .key_i     (key_q),
    .hit_o     (hit),
    .handler_o (handler)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    ptr_d     = ptr_q;
    issued_d  = issued_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    rsp_d     = rsp_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          rsp_d = '{status: StatusOk, matched: 1'b0, dispatch: 1'b0, match_index: 5'd0};
          if (req_i.kind == KindWrite) begin
            // Writes finish at once; refuse an index past the entries in use.
            if (!in_range) begin
              rsp_d.status = StatusIllegal;
            end
            state_d = S_OUT;
          end else if (count == '0) begin
            state_d = S_OUT;
          end else begin
            key_d    = {req_i.remote_flag, req_i.frame_ident};
            ptr_d    = '0;
            issued_d = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one table read per cycle until the last entry in use.
        if (rd_en) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = ptr_q;
          ptr_d     = ptr_q + IdxW'(1);
          if (ptr_q == last_idx) begin
            issued_d = 1'b1;
          end
        end
        // Compare the entry read last cycle; stop at the first hit.
        if (cmp_vld_q) begin
          if (hit) begin
            rsp_d.matched     = 1'b1;
            rsp_d.dispatch    = handler;
            rsp_d.match_index = 5'(cmp_idx_q);
            cmp_vld_d         = 1'b0;
            state_d           = S_OUT;
          end else if (cmp_idx_q == last_idx) begin
            cmp_vld_d = 1'b0;
            state_d   = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_q     <= CfgReset;
      issued_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issued_q  <= issued_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

endmodule

@@ sv/cidf_checker.sv @@
module cidf_checker import cidf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      req_valid_i,
  input logic      req_ready_o,
  input logic      rsp_valid_o,
  input logic      rsp_ready_i,
  input filt_rsp_t rsp_o
);

  // Hold a pending response until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("response dropped before it was taken");

  // One request in flight: no new request while a response waits.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && rsp_valid_o))
    else $error("ready while a response is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("ready right after accepting a request");

  // Refused writes and misses carry no match information.
  a_clean_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.matched |-> !rsp_o.dispatch && (rsp_o.match_index == 5'd0))
    else $error("miss response carries match data");

  a_refused_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.status == StatusIllegal) |-> !rsp_o.matched)
    else $error("refused write reports a match");

endmodule

bind can_id_mask_acceptance_filter_top cidf_checker u_cidf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

@@ tb/sv/cidf_tb_pkg.sv @@
package cidf_tb_pkg;
  import cidf_pkg::*;

  class acceptance_scoreboard;
    logic [KeyW-1:0] ident_tbl   [TableEntries];
    logic [KeyW-1:0] mask_tbl    [TableEntries];
    bit              handler_tbl [TableEntries];
    logic [CfgW-1:0] count_reg;
    filt_rsp_t       awaited_rsp [$];
    int unsigned     errors;

    function new();
      for (int i = 0; i < TableEntries; i++) begin
        ident_tbl[i]   = '0;
        mask_tbl[i]    = FullMask;
        handler_tbl[i] = 1'b0;
      end
      count_reg = CfgReset;
      errors    = 0;
    endfunction

    function void set_count(logic [CfgW-1:0] value);
      count_reg = value;
    endfunction

    // Count beyond the table size saturates for both search and write.
    function int unsigned searched_entries();
      return (count_reg > TableEntries) ? TableEntries : int'(count_reg);
    endfunction

    function void note_request(filt_req_t r);
      filt_rsp_t       rsp;
      logic [KeyW-1:0] key;
      int unsigned     span;
      rsp  = '0;
      key  = {r.remote_flag, r.frame_ident};
      span = searched_entries();
      if (r.kind == KindWrite) begin
        if (r.entry_index < span) begin
          ident_tbl[r.entry_index]   = key;
          mask_tbl[r.entry_index]    = {1'b0, r.accept_mask} | RtrBit;
          handler_tbl[r.entry_index] = 1'b1;
          rsp.status = StatusOk;
        end else begin
          rsp.status = StatusIllegal;
        end
      end else begin
        for (int i = 0; i < span; i++) begin
          if (((key ^ ident_tbl[i]) & mask_tbl[i]) == '0) begin
            rsp.matched     = 1'b1;
            rsp.dispatch    = handler_tbl[i];
            rsp.match_index = 5'(i);
            break;
          end
        end
      end
      awaited_rsp.push_back(rsp);
    endfunction

    function void flag_field(string field, int want, int got, longint unsigned now_ns);
      errors++;
      $display("%0d ns: %s mismatch, expected %0h, actual %0h", now_ns, field, want, got);
    endfunction

    function void check_response(filt_rsp_t got, longint unsigned now_ns);
      filt_rsp_t want;
      if (awaited_rsp.size() == 0) begin
        errors++;
        $display("%0d ns: response with nothing pending, expected none, actual %0h",
                 now_ns, got);
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status)
        flag_field("status", want.status, got.status, now_ns);
      if (got.matched !== want.matched)
        flag_field("matched", want.matched, got.matched, now_ns);
      if (got.dispatch !== want.dispatch)
        flag_field("dispatch", want.dispatch, got.dispatch, now_ns);
      if (got.match_index !== want.match_index)
        flag_field("match_index", want.match_index, got.match_index, now_ns);
    endfunction
  endclass

endpackage

@@ tb/sv/tb_can_id_mask_acceptance_filter_top.sv @@
module tb_can_id_mask_acceptance_filter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cidf_pkg::*;
  import cidf_tb_pkg::*;

  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned RandomPerPhase = 173;
  localparam int unsigned HoldOffCycles  = 300;
  // Margin for the worst frame scan plus the return to idle.
  localparam int unsigned DrainCycles    = 64;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            req_valid = 1'b0;
  filt_req_t       req_data  = '0;
  logic            rsp_ready = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CfgW-1:0] cfg_data  = '0;
  logic            req_ready;
  logic            rsp_valid;
  filt_rsp_t       rsp_data;
  logic            cfg_ready;

  // Stimulus-side view of the configured count, used to aim indexes.
  logic [CfgW-1:0] cur_count    = CfgReset;
  // Steady phases: no gaps on the request side, no stalls on the response side.
  bit              steady       = 1'b0;
  bit              hold_off_req = 1'b0;

  acceptance_scoreboard sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  can_id_mask_acceptance_filter_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req_data),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (steady || roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic filt_req_t mk_req(logic kind, logic [7:0] idx, logic [10:0] ident,
                                       logic rtr, logic [10:0] mask);
    filt_req_t r;
    r.kind        = kind;
    r.entry_index = idx;
    r.frame_ident = ident;
    r.remote_flag = rtr;
    r.accept_mask = mask;
    return r;
  endfunction

  // Build a random request. Writes mostly land inside the searched range,
  // with some at the boundary and some anywhere in the 8-bit index space.
  // Half of the frames aim at a live entry (don't-care bits scrambled, RTR
  // at times flipped) so that hits land deep in the table, not just on entry 0.
  function automatic filt_req_t random_request();
    filt_req_t       r;
    int unsigned     span;
    int unsigned     roll;
    int unsigned     slot;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] msk;
    span          = (cur_count > TableEntries) ? TableEntries : int'(cur_count);
    r.kind        = ($urandom_range(99) < 30) ? KindWrite : KindFrame;
    r.entry_index = 8'($urandom);
    r.frame_ident = 11'($urandom);
    r.remote_flag = 1'($urandom);
    r.accept_mask = 11'($urandom);
    roll          = $urandom_range(99);
    if (r.kind == KindWrite) begin
      if (span > 0 && roll < 75) r.entry_index = 8'($urandom_range(span - 1));
      else if (roll < 88) r.entry_index = 8'(span + $urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 25) r.accept_mask = 11'h7FF;
      else if (roll < 35) r.accept_mask = '0;
      else if (roll < 65) r.accept_mask = 11'($urandom & $urandom & $urandom);
    end else if (span > 0 && roll < 50) begin
      slot          = $urandom_range(span - 1);
      key           = sb.ident_tbl[slot];
      msk           = sb.mask_tbl[slot];
      r.frame_ident = key[10:0] ^ (11'($urandom) & ~msk[10:0]);
      r.remote_flag = ($urandom_range(9) == 0) ? ~key[11] : key[11];
    end else if (roll < 60) begin
      // data frame with identifier 0: caught by any never-written entry
      r.frame_ident = '0;
      r.remote_flag = 1'b0;
    end
    return r;
  endfunction

  // Offer one request and hold it until the block takes it. Valid is only
  // dropped when a gap precedes the request, so back-to-back requests keep
  // it high without a lower/raise in one step.
  task automatic send_req(input filt_req_t r);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (req_ready !== 1'b1);
    sb.note_request(r);
  endtask

  // Drop valid and wait until every pending response has been returned.
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Reprogram the count only once the block is idle.
  task automatic write_count(input logic [CfgW-1:0] value);
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_count(value);
    cur_count = value;
    cfg_valid <= 1'b0;
  endtask

  // Response side: check each handshake, then pick the next ready level.
  // Short stalls are common, long ones rare; a hold-off request from the
  // stimulus forces one very long stall so the block backs up its input.
  initial begin : rsp_side
    int unsigned stall_left;
    int unsigned roll;
    bit          hold_off_taken;
    stall_left     = 0;
    hold_off_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) sb.check_response(rsp_data, $time);
      if (hold_off_req && !hold_off_taken) begin
        stall_left     = HoldOffCycles;
        hold_off_taken = 1'b1;
      end else if (stall_left == 0 && !steady) begin
        roll = $urandom_range(99);
        if (roll < 20) stall_left = $urandom_range(4, 1);
        else if (roll < 22) stall_left = $urandom_range(50, 15);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs or drops a response.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CfgW-1:0] phase_counts [10];
    phase_counts = '{6'd7, 6'd63, 6'd1, 6'd20, 6'd0, 6'd33, 6'd32, 6'd12, 6'd2, 6'd0};
    phase_counts[9] = 6'($urandom_range(63));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset table, count 32: identifier-0 data frames hit a never-written
    // entry with no handler; RTR frames and all-ones identifiers miss.
    send_req(mk_req(KindFrame, 8'h00, 11'h000, 1'b0, 11'h000));
    send_req(mk_req(KindFrame, 8'hFF, 11'h000, 1'b1, 11'h7FF));
    send_req(mk_req(KindFrame, 8'h00, 11'h7FF, 1'b1, 11'h000));
    // Fill the extreme entries: all-ones remote entry at 0, data-frame wildcard at 31.
    send_req(mk_req(KindWrite, 8'd0, 11'h7FF, 1'b1, 11'h7FF));
    send_req(mk_req(KindFrame, 8'h00, 11'h7FF, 1'b1, 11'h000));
    send_req(mk_req(KindFrame, 8'h00, 11'h7FF, 1'b0, 11'h000));
    send_req(mk_req(KindWrite, 8'd31, 11'h123, 1'b0, 11'h000));
    send_req(mk_req(KindFrame, 8'h00, 11'h555, 1'b0, 11'h000));
    send_req(mk_req(KindFrame, 8'h00, 11'h000, 1'b0, 11'h000));
    // Refuse writes at and far beyond the entries in use.
    send_req(mk_req(KindWrite, 8'd32, 11'h0F0, 1'b0, 11'h7FF));
    send_req(mk_req(KindWrite, 8'd255, 11'h7FF, 1'b1, 11'h7FF));
    // Partial mask: only the top identifier bits compared.
    send_req(mk_req(KindWrite, 8'd5, 11'h2AA, 1'b0, 11'h700));
    send_req(mk_req(KindFrame, 8'h00, 11'h2FF, 1'b0, 11'h000));
    send_req(mk_req(KindFrame, 8'h00, 11'h2FF, 1'b1, 11'h000));

    // Count of zero: nothing searched, every write refused.
    write_count(6'd0);
    send_req(mk_req(KindFrame, 8'h00, 11'h000, 1'b0, 11'h000));
    send_req(mk_req(KindWrite, 8'd0, 11'h001, 1'b0, 11'h7FF));

    write_count(6'd1);
    send_req(mk_req(KindWrite, 8'd0, 11'h000, 1'b1, 11'h7FF));
    send_req(mk_req(KindWrite, 8'd1, 11'h000, 1'b1, 11'h7FF));
    send_req(mk_req(KindFrame, 8'h00, 11'h000, 1'b1, 11'h000));

    // Count above the table size saturates to the full table.
    write_count(6'd63);
    send_req(mk_req(KindWrite, 8'd31, 11'h400, 1'b0, 11'h7FF));
    send_req(mk_req(KindWrite, 8'd32, 11'h400, 1'b0, 11'h7FF));
    send_req(mk_req(KindFrame, 8'h00, 11'h400, 1'b0, 11'h000));

    write_count(6'd33);
    send_req(mk_req(KindFrame, 8'h00, 11'h7FF, 1'b1, 11'h000));

    // Random phases, each under its own count. Two phases run with no
    // idling at all; the saturated-count phase opens with a long hold-off
    // on the response side while requests keep coming.
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      steady = (p % 4 == 3);
      if (p == 1) hold_off_req = 1'b1;
      repeat (RandomPerPhase) send_req(random_request());
    end

    drain_responses();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
